// File: hdl/pn2d_pkg.sv
package pn2d_pkg;

   localparam int QF              = 24;
   localparam int COORD_FRAC_BITS = 8;
   localparam int OUT_FRAC_BITS   = 16;
   localparam int AW              = 8;
   localparam int DW              = 29;
   localparam int OUT_W           = 18;

   localparam logic [DW-1:0] QONE    = DW'(1) << QF;
   localparam int            OUT_MAX = 131071;
   localparam int            OUT_MIN = -131072;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_EVAL = 1'b1;

   localparam logic [1:0] GR_PP = 2'd0;
   localparam logic [1:0] GR_NP = 2'd1;
   localparam logic [1:0] GR_PN = 2'd2;
   localparam logic [1:0] GR_NN = 2'd3;

   typedef struct packed {
      logic          we;
      logic [AW-1:0] addr;
      logic [7:0]    data;
   } wr_type;

   // unsigned Q24 product, rounded half up
   function automatic logic [31:0] mul_u(input logic [27:0] a, input logic [27:0] b);
      logic [55:0] p;
      p = 56'(a) * 56'(b) + (56'(1) << (QF - 1));
      return p[QF+31:QF];
   endfunction

   // signed times unsigned Q24, rounded half away from zero
   function automatic logic signed [DW-1:0] mul_s(input logic signed [DW-1:0] a,
                                                  input logic [24:0] t);
      logic          neg;
      logic [DW-1:0] mag;
      logic [31:0]   r;
      neg = a[DW-1];
      mag = neg ? DW'(-a) : DW'(a);
      r   = mul_u(mag[27:0], {3'b000, t});
      return neg ? -$signed(r[DW-1:0]) : $signed(r[DW-1:0]);
   endfunction

   function automatic logic signed [DW-1:0] grad(input logic [1:0] h,
                                                 input logic signed [DW-1:0] dx,
                                                 input logic signed [DW-1:0] dy);
      logic signed [DW-1:0] g;
      unique case (h)
         GR_PP: g = dx + dy;
         GR_NP: g = dy - dx;
         GR_PN: g = dx - dy;
         GR_NN: g = -dx - dy;
         default: g = '0;
      endcase
      return g;
   endfunction

endpackage

// File: hdl/pn2d_ram.sv
module pn2d_ram (
   input  logic                         clock,
   input  logic                         en,
   input  pn2d_pkg::wr_type             wr,
   input  logic [pn2d_pkg::AW-1:0]      raddr0,
   input  logic [pn2d_pkg::AW-1:0]      raddr1,
   output logic [7:0]                   rdata0,
   output logic [7:0]                   rdata1
);

   logic [7:0] mem_ff [2**pn2d_pkg::AW];
   logic [7:0] rd0_ff, rd1_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         if (wr.we) begin
            mem_ff[wr.addr] <= wr.data;
         end
         rd0_ff <= mem_ff[raddr0];
         rd1_ff <= mem_ff[raddr1];
      end
   end

   assign rdata0 = rd0_ff;
   assign rdata1 = rd1_ff;

endmodule

// File: hdl/pn2d_fade.sv
module pn2d_fade (
   input  logic        clock,
   input  logic        en,
   input  logic [23:0] t,
   output logic [24:0] fade
);

   logic [24:0] t2_ff, t1_ff, t3_ff, fade_ff;
   logic [27:0] poly_ff;
   logic [31:0] t2_in, t3_in, fade_in;
   logic [28:0] poly_in;

   always_comb begin
      t2_in   = pn2d_pkg::mul_u({4'd0, t}, {4'd0, t});
      t3_in   = pn2d_pkg::mul_u({3'd0, t2_ff}, {3'd0, t1_ff});
      // 6t^2 - 15t + 10, always positive on [0,1)
      poly_in = 29'(t2_ff) * 29'd6 + (29'd10 << pn2d_pkg::QF) - 29'(t1_ff) * 29'd15;
      fade_in = pn2d_pkg::mul_u({3'd0, t3_ff}, poly_ff);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         t2_ff   <= t2_in[24:0];
         t1_ff   <= {1'b0, t};
         t3_ff   <= t3_in[24:0];
         poly_ff <= poly_in[27:0];
         fade_ff <= fade_in[24:0];
      end
   end

   assign fade = fade_ff;

endmodule

// File: hdl/perlin_noise_2d_eval.sv
// 2D improved Perlin noise, one point per beat. A load beat (opcode 0) writes one byte of the
// 256-entry permutation table; an evaluate beat (opcode 1) returns one noise_value, with
// one beat taken every cycle while the output is not stalled. The pipeline has seven register
// stages: two levels of table lookup, gradient formation, the x lerp multiply, the x lerp
// sums, the y lerp multiply and the final round and saturate.
// The fade polynomial (three multiply stages) runs beside the lookups.
// The table is held in three copies so that six lookups fit in one cycle; each copy is
// written when the load beat reaches the stage that reads it, so items keep program order.
// Entries read before any write are undefined. A stall on the result side holds every stage.
module perlin_noise_2d_eval #(
   parameter int COORD_FRAC_BITS = pn2d_pkg::COORD_FRAC_BITS,
   parameter int OUT_FRAC_BITS   = pn2d_pkg::OUT_FRAC_BITS
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic                      req_opcode,
   input  logic [7:0]                req_table_index,
   input  logic [7:0]                req_table_value,
   input  logic [15:0]               req_x_coord,
   input  logic [15:0]               req_y_coord,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic signed [17:0]        rsp_noise_value
);

   localparam int DW = pn2d_pkg::DW;
   localparam int QF = pn2d_pkg::QF;
   localparam int SH = QF + 1 - OUT_FRAC_BITS;

   logic adv, acc;
   logic rsp_valid_ff;

   // coordinate split
   logic [31:0] xs, ys;
   logic [39:0] xw, yw;
   logic [7:0]  xi, yi;
   logic [23:0] xf, yf;

   always_comb begin
      xs = {16'd0, req_x_coord} >> COORD_FRAC_BITS;
      ys = {16'd0, req_y_coord} >> COORD_FRAC_BITS;
      xw = {24'd0, req_x_coord} << (QF - COORD_FRAC_BITS);
      yw = {24'd0, req_y_coord} << (QF - COORD_FRAC_BITS);
      xi = xs[7:0];
      yi = ys[7:0];
      xf = xw[23:0];
      yf = yw[23:0];
   end

   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !adv;
   assign acc       = req_valid && adv;

   // stage 1: first hash level
   logic        v1_ff, ld1_ff;
   logic [7:0]  widx1_ff, wval1_ff, yi1_ff;
   logic [23:0] xf1_ff, yf1_ff;
   logic [7:0]  ha, hb;
   pn2d_pkg::wr_type wr_a, wr_bc;

   always_comb begin
      wr_a.we    = acc && (req_opcode == pn2d_pkg::OP_LOAD);
      wr_a.addr  = req_table_index;
      wr_a.data  = req_table_value;
      wr_bc.we   = ld1_ff;
      wr_bc.addr = widx1_ff;
      wr_bc.data = wval1_ff;
   end

   pn2d_ram u_ram_a (
      .clock(clock), .en(adv), .wr(wr_a),
      .raddr0(xi), .raddr1(xi + 8'd1),
      .rdata0(ha), .rdata1(hb)
   );

   // stage 2: second hash level, one copy per x corner
   logic [7:0] aa, ab, ba, bb;

   pn2d_ram u_ram_b (
      .clock(clock), .en(adv), .wr(wr_bc),
      .raddr0(ha + yi1_ff), .raddr1(ha + yi1_ff + 8'd1),
      .rdata0(aa), .rdata1(ab)
   );

   pn2d_ram u_ram_c (
      .clock(clock), .en(adv), .wr(wr_bc),
      .raddr0(hb + yi1_ff), .raddr1(hb + yi1_ff + 8'd1),
      .rdata0(ba), .rdata1(bb)
   );

   logic [24:0] u, w;

   pn2d_fade u_fade_x (.clock(clock), .en(adv), .t(xf), .fade(u));
   pn2d_fade u_fade_y (.clock(clock), .en(adv), .t(yf), .fade(w));

   logic        v2_ff;
   logic [23:0] xf2_ff, yf2_ff;

   // stage 3: corner gradients
   logic                 v3_ff;
   logic signed [DW-1:0] dx0, dx1, dy0, dy1;
   logic signed [DW-1:0] gaa_ff, gab_ff, gba_ff, gbb_ff;

   always_comb begin
      dx0 = $signed({5'd0, xf2_ff});
      dy0 = $signed({5'd0, yf2_ff});
      dx1 = dx0 - $signed(pn2d_pkg::QONE);
      dy1 = dy0 - $signed(pn2d_pkg::QONE);
   end

   // stage 4: x lerp products; 5: x lerp sums; 6: y lerp product
   logic                 v4_ff, v5_ff, v6_ff;
   logic signed [DW-1:0] p1_ff, p2_ff, gaa4_ff, gab4_ff;
   logic signed [DW-1:0] x1_ff, x2_ff, x16_ff, q_ff;
   logic [24:0]          w4_ff, w5_ff;

   // stage 7: bias, round, saturate
   logic signed [17:0]   rsp_noise_value_ff, noise_in;
   logic signed [DW:0]   vs;
   logic [DW:0]          mag, rnd;
   logic                 neg;

   always_comb begin
      vs  = (DW+1)'(x16_ff) + (DW+1)'(q_ff) + $signed({1'b0, pn2d_pkg::QONE});
      neg = vs[DW];
      mag = neg ? (DW+1)'(-vs) : (DW+1)'(vs);
      rnd = (mag + ((DW+1)'(1) << (SH - 1))) >> SH;
      priority if (!neg && rnd > (DW+1)'(pn2d_pkg::OUT_MAX)) begin
         noise_in = 18'(pn2d_pkg::OUT_MAX);
      end else if (neg && rnd > (DW+1)'(-pn2d_pkg::OUT_MIN)) begin
         noise_in = 18'(pn2d_pkg::OUT_MIN);
      end else begin
         noise_in = neg ? -$signed(rnd[17:0]) : $signed(rnd[17:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         ld1_ff       <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         v5_ff        <= 1'b0;
         v6_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         v1_ff        <= acc && (req_opcode == pn2d_pkg::OP_EVAL);
         ld1_ff       <= acc && (req_opcode == pn2d_pkg::OP_LOAD);
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
         v4_ff        <= v3_ff;
         v5_ff        <= v4_ff;
         v6_ff        <= v5_ff;
         rsp_valid_ff <= v6_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         widx1_ff <= req_table_index;
         wval1_ff <= req_table_value;
         yi1_ff   <= yi;
         xf1_ff   <= xf;
         yf1_ff   <= yf;
         xf2_ff   <= xf1_ff;
         yf2_ff   <= yf1_ff;
         gaa_ff   <= pn2d_pkg::grad(aa[1:0], dx0, dy0);
         gba_ff   <= pn2d_pkg::grad(ba[1:0], dx1, dy0);
         gab_ff   <= pn2d_pkg::grad(ab[1:0], dx0, dy1);
         gbb_ff   <= pn2d_pkg::grad(bb[1:0], dx1, dy1);
         p1_ff    <= pn2d_pkg::mul_s(gba_ff - gaa_ff, u);
         p2_ff    <= pn2d_pkg::mul_s(gbb_ff - gab_ff, u);
         gaa4_ff  <= gaa_ff;
         gab4_ff  <= gab_ff;
         w4_ff    <= w;
         x1_ff    <= gaa4_ff + p1_ff;
         x2_ff    <= gab4_ff + p2_ff;
         w5_ff    <= w4_ff;
         q_ff     <= pn2d_pkg::mul_s(x2_ff - x1_ff, w5_ff);
         x16_ff   <= x1_ff;
         rsp_noise_value_ff <= noise_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_noise_value = rsp_noise_value_ff;

   // a finished point reaches the output when the pipe moves
   a_last_stage: assert property (@(posedge clock) disable iff (reset)
      (v6_ff && adv) |=> rsp_valid_ff)
      else $error("evaluated point lost before output");

   // a held pipe keeps every valid bit
   a_hold: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable({v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff, ld1_ff}))
      else $error("pipeline moved while stalled");

   // a load beat never also counts as an evaluation
   a_excl: assert property (@(posedge clock) disable iff (reset)
      !(ld1_ff && v1_ff))
      else $error("load and evaluate both live in stage one");

endmodule

// File: test/pn2d_noise_checker.sv
module pn2d_noise_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic               req_opcode,
   input  logic [7:0]         req_table_index,
   input  logic [7:0]         req_table_value,
   input  logic [15:0]        req_x_coord,
   input  logic [15:0]        req_y_coord,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic signed [17:0] rsp_noise_value,
   output int                 fail_count,
   output int                 outstanding
);

   localparam int     QF    = pn2d_pkg::QF;
   localparam int     CFB   = pn2d_pkg::COORD_FRAC_BITS;
   localparam int     OFB   = pn2d_pkg::OUT_FRAC_BITS;
   localparam longint QUNIT = longint'(1) << QF;

   logic [7:0]         perm_shadow [256];
   logic signed [17:0] noise_expected [$];

   function automatic longint q_mul(input longint a, input longint b);
      return (a * b + (longint'(1) << (QF - 1))) >>> QF;
   endfunction

   // magnitude times fade weight, rounded half away from zero
   function automatic longint q_mul_signed(input longint a, input longint t);
      longint r;
      r = q_mul(a < 0 ? -a : a, t);
      return a < 0 ? -r : r;
   endfunction

   function automatic longint fade_curve(input longint t);
      longint t2, t3;
      t2 = q_mul(t, t);
      t3 = q_mul(t2, t);
      return q_mul(t3, 6 * t2 + 10 * QUNIT - 15 * t);
   endfunction

   function automatic longint corner_dot(input logic [1:0] h, input longint dx,
                                         input longint dy);
      longint g;
      case (h)
         pn2d_pkg::GR_PP: g = dx + dy;
         pn2d_pkg::GR_NP: g = dy - dx;
         pn2d_pkg::GR_PN: g = dx - dy;
         default: g = -dx - dy;
      endcase
      return g;
   endfunction

   function automatic logic signed [17:0] noise_at(input logic [15:0] x, input logic [15:0] y);
      logic [7:0] xi, yi, ha, hb, aa, ab, ba, bb, ix;
      longint     xf, yf, u, w, x1, x2, v, m;
      int         sh;
      xi = 8'(x >> CFB);
      yi = 8'(y >> CFB);
      xf = longint'(x & ((16'd1 << CFB) - 1)) << (QF - CFB);
      yf = longint'(y & ((16'd1 << CFB) - 1)) << (QF - CFB);
      u  = fade_curve(xf);
      w  = fade_curve(yf);
      ha = perm_shadow[xi];
      ix = xi + 8'd1;
      hb = perm_shadow[ix];
      ix = ha + yi;
      aa = perm_shadow[ix];
      ix = ha + yi + 8'd1;
      ab = perm_shadow[ix];
      ix = hb + yi;
      ba = perm_shadow[ix];
      ix = hb + yi + 8'd1;
      bb = perm_shadow[ix];
      x1 = corner_dot(aa[1:0], xf, yf);
      x1 = x1 + q_mul_signed(corner_dot(ba[1:0], xf - QUNIT, yf) - x1, u);
      x2 = corner_dot(ab[1:0], xf, yf - QUNIT);
      x2 = x2 + q_mul_signed(corner_dot(bb[1:0], xf - QUNIT, yf - QUNIT) - x2, u);
      v  = x1 + q_mul_signed(x2 - x1, w) + QUNIT;
      sh = QF + 1 - OFB;
      m  = ((v < 0 ? -v : v) + (longint'(1) << (sh - 1))) >>> sh;
      v  = v < 0 ? -m : m;
      if (v > pn2d_pkg::OUT_MAX) v = pn2d_pkg::OUT_MAX;
      if (v < pn2d_pkg::OUT_MIN) v = pn2d_pkg::OUT_MIN;
      return 18'(v);
   endfunction

   initial begin
      fail_count  = 0;
      outstanding = 0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            if (req_opcode == pn2d_pkg::OP_LOAD) perm_shadow[req_table_index] = req_table_value;
            else noise_expected.push_back(noise_at(req_x_coord, req_y_coord));
         end
         if (rsp_valid && !rsp_stall) begin
            if (noise_expected.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("unexpected result beat: noise_value %0d", rsp_noise_value);
            end else begin
               if (rsp_noise_value !== noise_expected[0]) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("noise_value mismatch: expected %0d, got %0d",
                              noise_expected[0], rsp_noise_value);
               end
               void'(noise_expected.pop_front());
            end
         end
         outstanding = noise_expected.size();
      end
   end
endmodule

// File: test/tb_perlin_noise_2d_eval.sv
module tb_perlin_noise_2d_eval;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic               req_opcode = pn2d_pkg::OP_LOAD;
   logic [7:0]         req_table_index = '0;
   logic [7:0]         req_table_value = '0;
   logic [15:0]        req_x_coord = '0;
   logic [15:0]        req_y_coord = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [17:0] rsp_noise_value;

   int fail_count, outstanding;
   int idle_cycles = 0;
   int beat_count  = 0;

   // receiver controls: a long hold-off request and the quiet tail with no idling
   bit long_hold = 1'b0;
   bit quiet     = 1'b0;

   localparam int RANDOM_BEATS = 1420;
   localparam int QUIET_TAIL   = 300;
   localparam int HOLD_CYCLES  = 300;
   localparam int WATCHDOG     = 5000;

   always #4 clock = ~clock;

   perlin_noise_2d_eval dut (
      .clock, .reset,
      .req_valid, .req_stall, .req_opcode, .req_table_index, .req_table_value,
      .req_x_coord, .req_y_coord,
      .rsp_valid, .rsp_stall, .rsp_noise_value
   );

   pn2d_noise_checker checker_i (
      .clock, .reset,
      .req_valid, .req_stall, .req_opcode, .req_table_index, .req_table_value,
      .req_x_coord, .req_y_coord,
      .rsp_valid, .rsp_stall, .rsp_noise_value,
      .fail_count, .outstanding
   );

   // Watchdog: cycles with no beat on either channel. A long hold-off is well under the limit.
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG) begin
            $display("Verification failed");
            $finish;
         end
      end
   end

   // Result side: random stall bursts, one long hold-off on request, none in the tail.
   // Each pass makes exactly one assignment to rsp_stall and then advances to a later clock edge.
   initial begin
      @(negedge reset);
      forever begin
         if (long_hold) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            long_hold = 1'b0;
         end else if (!quiet && $urandom_range(0, 7) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end else begin
            rsp_stall <= 1'b0;
            @(posedge clock);
         end
      end
   end

   // One beat: present it, hold until taken. Valid is left high; the task lowers it
   // only when it inserts a gap, so it never drops and rises in one step.
   task automatic send_beat(input logic op, input logic [7:0] idx, input logic [7:0] val,
                            input logic [15:0] x, input logic [15:0] y);
      req_valid       <= 1'b1;
      req_opcode      <= op;
      req_table_index <= idx;
      req_table_value <= val;
      req_x_coord     <= x;
      req_y_coord     <= y;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      beat_count++;
      if (!quiet && $urandom_range(0, 9) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   endtask

   task automatic send_eval(input logic [15:0] x, input logic [15:0] y);
      send_beat(pn2d_pkg::OP_EVAL, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                x, y);
   endtask

   task automatic send_load(input logic [7:0] idx, input logic [7:0] val);
      send_beat(pn2d_pkg::OP_LOAD, idx, val, 16'($urandom_range(0, 65535)),
                16'($urandom_range(0, 65535)));
   endtask

   function automatic logic [15:0] pick_coord();
      logic [15:0] c;
      c = 16'($urandom_range(0, 65535));
      case ($urandom_range(0, 9))
         0: c[7:0] = 8'h00;   // on a lattice point
         1: c[7:0] = 8'hFF;   // just short of the next cell
         2: c[7:0] = 8'h80;
         default: ;
      endcase
      return c;
   endfunction

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Fill the whole table first so no evaluate ever reads an unwritten entry.
      for (int i = 0; i < 256; i++) send_load(8'(i), 8'($urandom_range(0, 255)));

      // Directed: byte extremes on loads, coordinate extremes and cell wrap at 255.
      send_load(8'd0, 8'hFF);
      send_load(8'd255, 8'h00);
      send_eval(16'h0000, 16'h0000);
      send_eval(16'hFFFF, 16'hFFFF);
      send_eval(16'h00FF, 16'h00FF);
      send_eval(16'hFF00, 16'h0000);
      send_eval(16'h0000, 16'hFF00);
      send_eval(16'h0080, 16'h0080);
      send_eval(16'h0180, 16'h1180);
      send_eval(16'hAB40, 16'hFFC0);
      send_eval(16'h5555, 16'hAAAA);
      send_eval(16'hAAAA, 16'h5555);
      send_eval(16'h0001, 16'h00FE);
      send_eval(16'h7FFF, 16'h8000);
      send_eval(16'hFFFF, 16'h0000);
      send_eval(16'h0000, 16'hFFFF);
      send_load(8'hAA, 8'h55);
      send_load(8'h55, 8'hAA);
      send_eval(16'hAA00, 16'h5500);
      send_eval(16'h55FF, 16'hAAFF);

      for (int n = 0; n < RANDOM_BEATS; n++) begin
         if (n == 500) long_hold = 1'b1;   // receiver holds off, sender keeps offering
         if (n == 1000) begin               // sender drains the block before going on
            req_valid <= 1'b0;
            @(posedge clock);
            wait (outstanding == 0);
         end
         if (n == RANDOM_BEATS - QUIET_TAIL) quiet = 1'b1;
         if ($urandom_range(0, 9) == 0)
            send_load(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
         else
            send_eval(pick_coord(), pick_coord());
      end
      req_valid <= 1'b0;

      wait (outstanding == 0);
      repeat (20) @(posedge clock);
      if (fail_count == 0 && outstanding == 0) $display("Verification passed");
      else $display("Verification failed");
      $finish;
   end
endmodule
